// ===== rtl/scds_pkg.sv =====
package scds_pkg;

  localparam int unsigned RefClkResetHz = 32'd100_000_000;

  localparam logic [7:0] FactorLimit   = 8'hFF;
  localparam logic [7:0] PrescaleLimit = 8'hFE;
  localparam logic [7:0] DirectLimit   = 8'hFF;
  localparam logic [5:0] DataSize8     = 6'h07;

  // divider step counts, loaded as count minus one
  localparam logic [4:0] StepsFull = 5'd31;
  localparam logic [4:0] StepsHalf = 5'd15;

  // configuration register indexes
  localparam logic RegRefClk = 1'b0;

  typedef struct packed {
    logic [31:0] requested_rate_hz;
    logic [1:0]  spi_mode;
  } scds_in_t;

  typedef struct packed {
    logic [15:0] control_word;
    logic [8:0]  prescale_value;
    logic [7:0]  rate_factor_minus_one;
  } scds_out_t;

  typedef struct packed {
    logic start;
    logic half;   // 16-bit dividend, 16 steps
  } scds_div_ctl_t;

endpackage

// ===== rtl/scds_div.sv =====
module scds_div import scds_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  scds_div_ctl_t ctl_i,
  input  logic [31:0]   dividend_i,
  input  logic [31:0]   divisor_i,
  output logic [31:0]   quot_o,
  output logic [31:0]   rem_o,
  output logic          done_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] div_q, div_d;

  logic [32:0] shifted;
  logic [32:0] diff;
  logic        ge;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign shifted = {rem_q, quo_q[31]};
  assign diff    = shifted - {1'b0, div_q};
  assign ge      = shifted >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (ctl_i.start && !busy_q) begin
      busy_d = 1'b1;
      rem_d  = '0;
      div_d  = divisor_i;
      // a short dividend sits in the top half so only 16 steps are needed
      quo_d  = ctl_i.half ? {dividend_i[15:0], 16'h0000} : dividend_i;
      cnt_d  = ctl_i.half ? StepsHalf : StepsFull;
    end else if (busy_q) begin
      rem_d = ge ? diff[31:0] : shifted[31:0];
      quo_d = {quo_q[30:0], ge};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  // zero divisor gives an all-ones quotient
  assign quot_o = quo_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

// ===== rtl/spi_clock_divider_select.sv =====
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-----------------------------
// in       | input     | in_valid_i / in_stall_o | scds_in_t  (rate, mode)
// out      | output    | out_valid_o/ out_stall_i| scds_out_t (ctrl, presc, rf)
// cfg      | input     | APB, pready tied high   | reference_clock_hz at 0x0
//
// One item at a time through a shared restoring divider (one bit per cycle).
// The 32-bit ratio division runs first; each factor trial is then a 16-step division,
// and an item holds the input until its result is written to the output register.
// in_stall_o is high while an item is in work; the result sits in an output
// register, so a stalled output only delays the end of the next item.
// Async active-low reset; reference clock resets to 100 MHz.
module spi_clock_divider_select import scds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  scds_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output scds_out_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RATIO = 2'd1;
  localparam logic [1:0] ST_TRY   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]  state_q, state_d;
  logic [31:0] ref_clk_q;
  logic [1:0]  mode_q, mode_d;
  logic [15:0] ratio_q, ratio_d;
  logic [7:0]  factor_q, factor_d;
  logic [7:0]  presc_q, presc_d;
  logic        out_valid_q, out_valid_d;
  scds_out_t   out_q, out_d;

  scds_div_ctl_t div_ctl;
  logic [31:0]   div_dividend, div_divisor;
  logic [31:0]   div_quot, div_rem;
  logic          div_done;
  logic          in_accept;
  logic          cfg_wr;
  logic [8:0]    presc_fixed;
  logic [7:0]    factor_m1;

  scds_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (div_quot),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegRefClk);
  assign prdata = (paddr[2] == RegRefClk) ? ref_clk_q : '0;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // minimum of 2, then round up to even
  assign presc_fixed = (presc_q < 8'd2) ? 9'd2
                                        : ({1'b0, presc_q} + {8'b0, presc_q[0]});
  assign factor_m1   = factor_q - 8'd1;

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    ratio_d      = ratio_q;
    factor_d     = factor_q;
    presc_d      = presc_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    div_ctl      = '0;
    div_dividend = ref_clk_q;
    div_divisor  = in_data_i.requested_rate_hz;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          mode_d        = in_data_i.spi_mode;
          div_ctl.start = 1'b1;
          state_d       = ST_RATIO;
        end
      end
      ST_RATIO: begin
        if (div_done) begin
          ratio_d  = div_quot[15:0];
          factor_d = 8'd1;
          if (div_quot[15:0] <= {8'h00, DirectLimit}) begin
            presc_d = div_quot[7:0];
            state_d = ST_DONE;
          end else begin
            div_ctl.start = 1'b1;
            div_ctl.half  = 1'b1;
            div_dividend  = {16'h0000, div_quot[15:0]};
            div_divisor   = 32'd1;
            state_d       = ST_TRY;
          end
        end
      end
      ST_TRY: begin
        div_dividend = {16'h0000, ratio_q};
        div_divisor  = {24'h000000, factor_q + 8'd1};
        if (div_done) begin
          if (div_rem == '0 && div_quot <= {24'h000000, PrescaleLimit}) begin
            presc_d = div_quot[7:0];
            state_d = ST_DONE;
          end else if (factor_q == FactorLimit) begin
            // no exact fit: last trial already holds ratio / 255
            presc_d = div_quot[7:0] & PrescaleLimit;
            state_d = ST_DONE;
          end else begin
            factor_d      = factor_q + 8'd1;
            div_ctl.start = 1'b1;
            div_ctl.half  = 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d                 = 1'b1;
          out_d.control_word          = {factor_m1, mode_q[0], mode_q[1], DataSize8};
          out_d.prescale_value        = presc_fixed;
          out_d.rate_factor_minus_one = factor_m1;
          state_d                     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ref_clk_q   <= RefClkResetHz;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_wr) begin
        ref_clk_q <= pwdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    ratio_q  <= ratio_d;
    factor_q <= factor_d;
    presc_q  <= presc_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/scds_checker.sv =====
module scds_checker import scds_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input scds_out_t out_data_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an accepted item keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting an item");

  a_presc_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.prescale_value[0] == 1'b0) &&
                    (out_data_o.prescale_value >= 9'd2) &&
                    (out_data_o.prescale_value <= 9'd256))
    else $error("prescale out of range or odd");

  a_ctrl_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.control_word[15:8] ==
                     out_data_o.rate_factor_minus_one) &&
                    (out_data_o.control_word[5:0] == DataSize8) &&
                    (out_data_o.rate_factor_minus_one != FactorLimit))
    else $error("control word does not match rate factor");

endmodule

bind spi_clock_divider_select scds_checker u_scds_checker (.*);
